// ===== sv/circle_accumulate_ascii_raster_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circle raster block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_ACCUMULATE_ASCII_RASTER_TOP_DEFINES_SVH
`define CIRCLE_ACCUMULATE_ASCII_RASTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/car_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle raster package
// Shared constants, the control bundle for the pixel unit and the ramp lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package car_pkg;

  localparam int CAR_MAX_WIDTH  = 256;
  localparam int CAR_MAX_HEIGHT = 128;

  // Request operation codes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_IDX_W         = 1;
  localparam logic [0:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [0:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam int         SCR_W_W = 9;
  localparam int         SCR_H_W = 8;
  localparam logic [8:0] SCR_W_RESET = 9'd80;
  localparam logic [7:0] SCR_H_RESET = 8'd24;

  localparam logic [6:0] CHAR_SPACE = 7'd32;

  localparam logic [6:0] RAMP [8] = '{7'd32, 7'd46, 7'd44, 7'd59,
                                      7'd111, 7'd79, 7'd48, 7'd64};

  // Per-circle parameters handed to the pixel unit.
  typedef struct packed {
    logic              vld;
    logic signed [9:0] center_x;
    logic signed [8:0] center_y;
    logic signed [4:0] shade;
    logic [17:0]       r2;
  } pix_ctl_t;

  function automatic logic [6:0] ramp_char(input logic signed [7:0] v);
    logic [6:0] c;
    if (v < 8'sd0) begin
      c = RAMP[0];
    end else if (v > 8'sd7) begin
      c = RAMP[7];
    end else begin
      c = RAMP[v[2:0]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/car_frame_mem.sv =====
// ----------------------------------------------------------------------------
// Framebuffer memory
// Simple dual-port cell store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module car_frame_mem #(
  parameter int DEPTH = car_pkg::CAR_MAX_WIDTH * car_pkg::CAR_MAX_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] cells_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cells_r[waddr] <= wdata;
    end
    rdata_r <= cells_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/car_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// Circle pixel unit
// Two-stage read-modify-write path: squared distances, then test and add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module car_pixel_unit #(
  parameter int MAX_WIDTH  = car_pkg::CAR_MAX_WIDTH,
  parameter int MAX_HEIGHT = car_pkg::CAR_MAX_HEIGHT
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire car_pkg::pix_ctl_t                           ctl,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]                x,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]               y,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     addr,
  input  wire logic [7:0]                                  rd_data,
  output logic                                             wr_en,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]          wr_addr,
  output logic [7:0]                                       wr_data
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DXW = ((XW > 10) ? XW : 10) + 2;
  localparam int DYW = ((YW > 9) ? YW : 9) + 2;
  localparam int SQW = 2 * ((DXW > DYW) ? DXW : DYW);

  logic signed [DXW-1:0] dx;
  logic signed [DYW-1:0] dy;
  logic signed [SQW-1:0] dxe, dye;
  logic [SQW-1:0]        dx2_nxt, dy2_nxt;
  logic [SQW-1:0]        dx2_r, dy2_r;
  logic [AW-1:0]         addr_r;
  logic                  vld_r;
  logic [SQW:0]          dist_sum;
  logic                  hit;
  logic signed [8:0]     sum;
  logic signed [7:0]     cur_cell;

  // Stage 0: offsets from the center and their squares. The offsets are
  // widened to the product width first so that the squares keep every bit.
  always_comb begin
    dx = $signed({{(DXW-XW){1'b0}}, x}) - $signed({{(DXW-10){ctl.center_x[9]}}, ctl.center_x});
    dy = $signed({{(DYW-YW){1'b0}}, y}) - $signed({{(DYW-9){ctl.center_y[8]}}, ctl.center_y});
    dxe = {{(SQW-DXW){dx[DXW-1]}}, dx};
    dye = {{(SQW-DYW){dy[DYW-1]}}, dy};
    dx2_nxt = $unsigned(dxe * dxe);
    dy2_nxt = $unsigned(dye * dye);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    dx2_r  <= dx2_nxt;
    dy2_r  <= dy2_nxt;
    addr_r <= addr;
  end

  // Stage 1: strict inside test and saturating add on the fetched cell.
  always_comb begin
    cur_cell = $signed(rd_data);
    dist_sum = {1'b0, dx2_r} + {1'b0, dy2_r};
    hit      = dist_sum < (SQW + 1)'(ctl.r2);
    sum      = $signed({cur_cell[7], cur_cell}) + $signed({{4{ctl.shade[4]}}, ctl.shade});
    if (sum > 9'sd127) begin
      wr_data = 8'h7F;
    end else if (sum < -9'sd128) begin
      wr_data = 8'h80;
    end else begin
      wr_data = sum[7:0];
    end
  end

  assign wr_en   = vld_r && hit;
  assign wr_addr = addr_r;

endmodule

`default_nettype wire

// ===== sv/circle_accumulate_ascii_raster_top.sv =====
// ----------------------------------------------------------------------------
// Filled circle brightness raster with ASCII read-out
// Signed 8-bit cells in one synchronous memory, swept per clear or draw request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      request    in_valid / in_ready    op, center_x, center_y, radius, shade
//   out_     result     out_valid / out_ready  char_code
//   cfg_     write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A clear request writes one cell per cycle across all MAX_WIDTH*MAX_HEIGHT cells.
// A circle request on an effective W by H screen reads all W*H cells, writes back
// those inside the circle, then finishes the last write-back in ST_DRAIN; an empty
// screen skips the sweep. A read request fetches its cell in ST_RD and loads the
// result in ST_RD_OUT, waiting there while the output register is still full, then
// returns to idle. After reset the same clearing pass runs before the first request
// is taken; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "circle_accumulate_ascii_raster_top_defines.svh"

module circle_accumulate_ascii_raster_top #(
  parameter int MAX_WIDTH  = car_pkg::CAR_MAX_WIDTH,
  parameter int MAX_HEIGHT = car_pkg::CAR_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_op,
  input  wire logic signed [9:0]             in_center_x,
  input  wire logic signed [8:0]             in_center_y,
  input  wire logic [8:0]                    in_radius,
  input  wire logic signed [4:0]             in_shade,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [6:0]                         out_char_code,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [car_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [car_pkg::SCR_W_W-1:0]   cfg_data
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN,
    ST_RD,
    ST_RD_OUT
  } state_t;

  state_t                        state_r;
  logic [car_pkg::SCR_W_W-1:0]   scr_w_r;
  logic [car_pkg::SCR_H_W-1:0]   scr_h_r;
  logic [AW-1:0]                 clr_addr_r;
  logic [XW-1:0]                 x_r, wl_r, wl_nxt;
  logic [YW-1:0]                 y_r, hl_r, hl_nxt;
  logic [AW-1:0]                 row_r;
  logic                          empty_nxt, empty_r;
  logic signed [9:0]             cx_r;
  logic signed [8:0]             cy_r;
  logic signed [4:0]             shade_r;
  logic [17:0]                   r2_r;
  logic                          out_valid_r;
  logic [6:0]                    out_char_r;

  logic                          in_acc;
  logic                          rd_oob;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 sweep_addr;
  logic [AW-1:0]                 mem_raddr, mem_waddr;
  logic                          mem_we;
  logic [7:0]                    mem_wdata, mem_rdata;
  car_pkg::pix_ctl_t             pix_ctl;
  logic                          pix_we;
  logic [AW-1:0]                 pix_waddr;
  logic [7:0]                    pix_wdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // Effective screen extents, latched when a request is taken.
  always_comb begin
    empty_nxt = (scr_w_r == '0) || (scr_h_r == '0);
    wl_nxt = (int'(scr_w_r) > MAX_WIDTH) ? XW'(MAX_WIDTH - 1) : XW'(scr_w_r - 9'd1);
    hl_nxt = (int'(scr_h_r) > MAX_HEIGHT) ? YW'(MAX_HEIGHT - 1) : YW'(scr_h_r - 8'd1);
  end

  // Read address and the off-screen check for a pixel read.
  always_comb begin
    rd_oob  = empty_r || (cx_r < 10'sd0) || (cy_r < 9'sd0) ||
              (int'(cx_r) > int'(wl_r)) || (int'(cy_r) > int'(hl_r));
    rd_addr = AW'(int'(cy_r) * MAX_WIDTH + int'(cx_r));
  end

  assign sweep_addr = row_r + AW'(x_r);

  // The sweep owns the read port while drawing; otherwise the read request does.
  assign mem_raddr = (state_r == ST_DRAW) ? sweep_addr : rd_addr;

  // The clearing pass owns the write port in its own state.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = pix_we;
      mem_waddr = pix_waddr;
      mem_wdata = pix_wdata;
    end
  end

  always_comb begin
    pix_ctl.vld      = (state_r == ST_DRAW);
    pix_ctl.center_x = cx_r;
    pix_ctl.center_y = cy_r;
    pix_ctl.shade    = shade_r;
    pix_ctl.r2       = r2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      scr_w_r     <= car_pkg::SCR_W_RESET;
      scr_h_r     <= car_pkg::SCR_H_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          car_pkg::REG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
          car_pkg::REG_SCREEN_HEIGHT: scr_h_r <= cfg_data[car_pkg::SCR_H_W-1:0];
          default: ;
        endcase
      end

      // In the read-out state the output register is reloaded whenever the
      // old result leaves, so the plain drain only applies elsewhere.
      if (out_valid_r && out_ready && (state_r != ST_RD_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          if (clr_addr_r == AW'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
          clr_addr_r <= clr_addr_r + 1'b1;
        end
        ST_IDLE: begin
          if (in_acc) begin
            cx_r    <= in_center_x;
            cy_r    <= in_center_y;
            shade_r <= in_shade;
            r2_r    <= in_radius * in_radius;
            wl_r    <= wl_nxt;
            hl_r    <= hl_nxt;
            empty_r <= empty_nxt;
            x_r     <= '0;
            y_r     <= '0;
            row_r   <= '0;
            priority if (in_op == car_pkg::OP_CLEAR) begin
              clr_addr_r <= '0;
              state_r    <= ST_CLEAR;
            end else if (in_op == car_pkg::OP_DRAW) begin
              state_r <= empty_nxt ? ST_IDLE : ST_DRAW;
            end else if (in_op == car_pkg::OP_READ) begin
              state_r <= ST_RD;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_DRAW: begin
          if (x_r == wl_r) begin
            x_r   <= '0;
            y_r   <= y_r + 1'b1;
            row_r <= row_r + AW'(MAX_WIDTH);
            if (y_r == hl_r) begin
              state_r <= ST_DRAIN;
            end
          end else begin
            x_r <= x_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          // The last pixel's write-back lands in this cycle.
          state_r <= ST_IDLE;
        end
        ST_RD: begin
          state_r <= ST_RD_OUT;
        end
        ST_RD_OUT: begin
          // The read address is held, so the fetched cell stays on the port
          // for as long as the output register is still occupied.
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_char_r  <= rd_oob ? car_pkg::CHAR_SPACE : car_pkg::ramp_char(mem_rdata);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;

  car_frame_mem #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  car_pixel_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pix (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (pix_ctl),
    .x      (x_r),
    .y      (y_r),
    .addr   (sweep_addr),
    .rd_data(mem_rdata),
    .wr_en  (pix_we),
    .wr_addr(pix_waddr),
    .wr_data(pix_wdata)
  );

  `CAR_ASSERT_NOW(a_idle_no_write, in_ready, !mem_we, "memory written while idle")
  `CAR_ASSERT_NOW(a_pix_write_in_draw, pix_we,
                  (state_r == ST_DRAW) || (state_r == ST_DRAIN),
                  "pixel write outside a circle sweep")
  `CAR_ASSERT_NEXT(a_result_from_read, !out_valid_r,
                   !out_valid_r || ($past(state_r) == ST_RD_OUT),
                   "result produced without a read")
  `CAR_ASSERT_NEXT(a_read_path, in_acc && (in_op == car_pkg::OP_READ),
                   state_r == ST_RD, "read request did not start a fetch")

endmodule

`default_nettype wire
